// ----- src/okl_pkg.sv -----
// Package for the obfuscated key lookup: cipher constants, obfuscated table and mask function.
package okl_pkg;

  localparam int unsigned TABLE_DEPTH = 63;
  localparam int unsigned KLQ_ROUNDS  = 528;

  localparam logic [63:0] MASK_KEY_HI = 64'h1B7A4C2E93F5A681;
  localparam logic [63:0] MASK_KEY_LO = 64'hC4E9D30F2A75B18C;
  localparam logic [31:0] MIX_MULT    = 32'h01000193;
  localparam logic [31:0] SEED_HI     = 32'hA5A50000;
  localparam logic [31:0] SEED_LO     = 32'h5A5A5A5A;
  localparam logic [31:0] KLQ_NLF     = 32'h3A5C742E;

  localparam int unsigned SERIAL_W = 32;
  localparam int unsigned FAMILY_W = 10;
  localparam int unsigned FIELD_LO = 12;
  localparam int unsigned FIELD_W  = SERIAL_W - FIELD_LO;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned KIDX_W   = 6;

  typedef logic [KEY_W-1:0] key_word_t;

  localparam key_word_t OBF_TABLE [TABLE_DEPTH] = '{
    64'hA4D87A18212ABBD3, 64'h66FC3402B786F87A, 64'hE68DC12D255BC510,
    64'hE37208B6ED66811D, 64'h86245395FFC36BAB, 64'hCE4206992A2E788A,
    64'h8F3172C24954A14F, 64'hF8D43DE0FF9A09AC, 64'hEDF6D4E357EC9F89,
    64'h90DDB2C3FA640217, 64'hDA57A47D5E61F6C3, 64'hCA2010C56F2A0C83,
    64'hFF7AA4DF94617C30, 64'h0009DCBCAC0CEC81, 64'h0038E127D1DB1BF7,
    64'h5359C4A1DBF8A2A9, 64'hC8BC2C2D08631C46, 64'hD31FA18A4DFEDF3A,
    64'hA83128C024D043B5, 64'hB64098EEFCFC5C7C, 64'h66B4E8C103A63E5D,
    64'h49EFD391BF78BA0B, 64'hC02A7CD958C1245C, 64'h73C52416A55DA983,
    64'hE35AF6CDC03B68ED, 64'h16B7AD3204A6603E, 64'h4F7108922F9A28B9,
    64'h4B13AB79E9B4C271, 64'h0A92369587447165, 64'h79E797E127508A5A,
    64'h913895A16A916E69, 64'hB3C8EED93B035CDB, 64'h7A871DA573459E60,
    64'h86C31AFCACD61968, 64'hCC0A8748FBF74CC9, 64'h9F86A0E7C3D9272F,
    64'h0A846BFAF2E70AEA, 64'h79AF70DB7CE32C71, 64'hA189A995DD8066A4,
    64'h77DF3D7AA98164D6, 64'h7EC18EB2C41D6464, 64'h31E7071BEA7A8AF5,
    64'h8DEE7F954CB98537, 64'hC0A8AAD5C8C3D69C, 64'h8BC8C76C89E74243,
    64'hF9549F513B81E1B7, 64'h43ECCDA69D808B50, 64'hD4C5F8C942253991,
    64'h4CC467DD69550D40, 64'h152FB68923A7CE9F, 64'hFEBCB715155F095D,
    64'h98B684682FB89F0E, 64'h5625854712957BC4, 64'h862B709443849C5A,
    64'h12D6B2773DA73151, 64'h4638DD11BF354FDB, 64'hEC4B1FDF31A5E0FE,
    64'hC8A38B1969D0F0D7, 64'h2558AD7C97D6BEC3, 64'hD5C7A22836E0A1C0,
    64'hF82158A02D17D790, 64'h99E73F22946FB64F, 64'h7A7DE82B37602F7D
  };

  // Standard KeeLoq encryption; only ever evaluated on constants to fill the mask ROM.
  function automatic logic [31:0] klq_encrypt(input logic [31:0] block,
                                               input logic [63:0] key);
    logic [31:0] x;
    logic [4:0]  sel;
    logic        fb;
    x = block;
    for (int r = 0; r < KLQ_ROUNDS; r++) begin
      sel = {x[31], x[26], x[20], x[9], x[1]};
      fb  = x[0] ^ x[16] ^ key[r % 64] ^ KLQ_NLF[sel];
      x   = {fb, x[31:1]};
    end
    return x;
  endfunction

  function automatic key_word_t index_mask(input int unsigned i);
    logic [31:0] mixed;
    mixed = 32'(i) * MIX_MULT;
    return {klq_encrypt(SEED_HI ^ mixed, MASK_KEY_HI),
            klq_encrypt(SEED_LO ^ mixed, MASK_KEY_LO)};
  endfunction

  // Entries past the stored table hold zero.
  function automatic key_word_t obf_word(input int unsigned i);
    key_word_t w;
    w = '0;
    if (i < TABLE_DEPTH) begin
      w = OBF_TABLE[i];
    end
    return w;
  endfunction

endpackage

// ----- src/okl_key_rom.sv -----
// Obfuscated word ROM and per-index mask ROM, both with a registered read port.
module okl_key_rom #(
  parameter int unsigned KEY_COUNT = 63,
  parameter int unsigned IDX_W     = 6
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output okl_pkg::key_word_t    rd_obf,
  output okl_pkg::key_word_t    rd_mask
);

  typedef okl_pkg::key_word_t rom_t [KEY_COUNT];

  function automatic rom_t build_obf();
    rom_t t;
    for (int unsigned i = 0; i < KEY_COUNT; i++) begin
      t[i] = okl_pkg::obf_word(i);
    end
    return t;
  endfunction

  function automatic rom_t build_mask();
    rom_t t;
    for (int unsigned i = 0; i < KEY_COUNT; i++) begin
      t[i] = okl_pkg::index_mask(i);
    end
    return t;
  endfunction

  localparam rom_t OBF_MEM  = build_obf();
  localparam rom_t MASK_MEM = build_mask();

  okl_pkg::key_word_t obf_r;
  okl_pkg::key_word_t mask_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      obf_r  <= OBF_MEM[rd_addr];
      mask_r <= MASK_MEM[rd_addr];
    end
  end

  assign rd_obf  = obf_r;
  assign rd_mask = mask_r;

endmodule

// ----- src/obfuscated_key_lookup_keeloq_top.sv -----
// Top level of the obfuscated key lookup: serial decode, ROM read and key recovery.
//
//   channel  ports                                      handshake
//   input    start, busy, in_serial                     start & !busy
//   result   out_valid, out_found, out_device_key,      out_valid, one cycle
//            out_key_index
//   config   cfg_valid, cfg_ready, cfg_data             cfg_valid & cfg_ready
//
// One serial beat is taken every cycle; busy never rises. Each result passes through
// the registered ROM read and then the output register that holds the obfuscated
// word XOR the mask. Reset is synchronous and active low; it clears the valid
// pipeline and the family marker, while the ROM contents are fixed. The receiver
// cannot stall, so every result is shown for exactly one cycle.
module obfuscated_key_lookup_keeloq_top #(
  parameter int unsigned KEY_COUNT = 63
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [okl_pkg::SERIAL_W-1:0]           in_serial,
  output logic                                   out_valid,
  output logic                                   out_found,
  output logic [okl_pkg::KEY_W-1:0]              out_device_key,
  output logic [okl_pkg::KIDX_W-1:0]             out_key_index,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [okl_pkg::FAMILY_W-1:0]           cfg_data
);

  localparam int unsigned IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // The block never pushes back on either the input or the config channel.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [okl_pkg::FAMILY_W-1:0] family_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      family_r <= cfg_data;
    end
  end

  // Decode: the upper field holds index plus one, so a field of zero wraps and
  // misses, and any field above the key count is out of range.
  logic                          accept;
  logic [okl_pkg::FIELD_W-1:0]   field;
  logic [okl_pkg::FIELD_W-1:0]   idx_full;
  logic                          hit;

  assign accept   = start && !busy;
  assign field    = in_serial[okl_pkg::SERIAL_W-1:okl_pkg::FIELD_LO];
  assign idx_full = field - okl_pkg::FIELD_W'(1);
  assign hit      = (in_serial[okl_pkg::FAMILY_W-1:0] == family_r) &&
                    (field != '0) &&
                    (field <= okl_pkg::FIELD_W'(KEY_COUNT));

  okl_pkg::key_word_t rd_obf;
  okl_pkg::key_word_t rd_mask;

  okl_key_rom #(
    .KEY_COUNT (KEY_COUNT),
    .IDX_W     (IDX_W)
  ) u_rom (
    .clk     (clk),
    .rd_en   (accept && hit),
    .rd_addr (idx_full[IDX_W-1:0]),
    .rd_obf  (rd_obf),
    .rd_mask (rd_mask)
  );

  // Stage one travels alongside the ROM read.
  logic                         s1_valid_r;
  logic                         s1_hit_r;
  logic [okl_pkg::KIDX_W-1:0]   s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r <= hit;
      s1_idx_r <= idx_full[okl_pkg::KIDX_W-1:0];
    end
  end

  // Stage two: recover the key, zeroing everything on a miss.
  logic                         out_valid_r;
  logic                         found_r;
  okl_pkg::key_word_t           key_r;
  logic [okl_pkg::KIDX_W-1:0]   kidx_r;
  logic                         found_nxt;
  okl_pkg::key_word_t           key_nxt;
  logic [okl_pkg::KIDX_W-1:0]   kidx_nxt;

  always_comb begin
    found_nxt = s1_hit_r;
    key_nxt   = s1_hit_r ? (rd_obf ^ rd_mask) : '0;
    kidx_nxt  = s1_hit_r ? s1_idx_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      found_r <= found_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_device_key = key_r;
  assign out_key_index  = kidx_r;

endmodule
